### design/response_packet_deframer_crc32_core_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef RESPONSE_PACKET_DEFRAMER_CRC32_CORE_MACROS_SVH
`define RESPONSE_PACKET_DEFRAMER_CRC32_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RPD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RPD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define RPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### design/rpd_pkg.sv
// Types, codes and the CRC-32 table for the response packet deframer.
package rpd_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_CHAR,
      PH_ERRB,
      PH_PAYLOAD,
      PH_CRC,
      PH_FLUSH
   } phase_type;

   // final status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_FIRST  = 3'd1;
   localparam logic [2:0] ST_TOO_SMALL  = 3'd2;
   localparam logic [2:0] ST_BAD_CHAR   = 3'd3;
   localparam logic [2:0] ST_WRONG_SIZE = 3'd4;
   localparam logic [2:0] ST_REMOTE     = 3'd5;
   localparam logic [2:0] ST_BUF_SMALL  = 3'd6;
   localparam logic [2:0] ST_CRC_BAD    = 3'd7;

   // configuration register indexes
   localparam logic [1:0] CSR_CRC_CHAR   = 2'd0;
   localparam logic [1:0] CSR_PLAIN_CHAR = 2'd1;
   localparam logic [1:0] CSR_EXT_CODE   = 2'd2;
   localparam logic [1:0] CSR_CAPACITY   = 2'd3;

   localparam logic [6:0]  EXT_CODE_RESET = 7'd127;
   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

   // queue between classifier and parser
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   typedef struct packed {
      logic [7:0]  crc_char;
      logic [7:0]  plain_char;
      logic [6:0]  ext_code;
      logic [15:0] capacity;
   } cfg_type;

   // one received byte with its state-free classification
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_odd;
      logic       is_ext;
      logic       len_lt2;
      logic       is_crc_char;
      logic       is_plain_char;
      logic       is_zero;
   } item_class_type;

   typedef logic [31:0] crc_table_type [256];

   // reflected CRC-32 byte table, built at elaboration
   function automatic crc_table_type crc_table_build();
      crc_table_type t;
      logic [31:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_table_type CRC_TABLE = crc_table_build();

   function automatic logic [31:0] crc_byte_update(input logic [31:0] c, input logic [7:0] b);
      return (c >> 8) ^ CRC_TABLE[c[7:0] ^ b];
   endfunction

endpackage

### design/rpd_ifs.sv
// Valid/ready channel interfaces for the deframer ports.
interface rpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        packet_done;
   logic [2:0]  status;
   logic [7:0]  remote_error;
   logic [15:0] payload_length;

   modport source (output valid, output payload_byte, output payload_valid,
                   output packet_done, output status, output remote_error,
                   output payload_length, input ready);
   modport sink   (input valid, input payload_byte, input payload_valid,
                   input packet_done, input status, input remote_error,
                   input payload_length, output ready);
endinterface

interface rpd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/rpd_front.sv
// Input side: accepts received bytes and classifies them against the config.
module rpd_front import rpd_pkg::*; (
   rpd_req_if.sink        req_chan,
   input  cfg_type        cfg,
   output logic           wr_valid,
   input  logic           wr_ready,
   output item_class_type wr_item
);

   // accept whenever the queue has room
   assign req_chan.ready = wr_ready;
   assign wr_valid       = req_chan.valid;

   // state-free byte classification
   always_comb begin
      wr_item.rx_byte       = req_chan.rx_byte;
      wr_item.is_odd        = req_chan.rx_byte[0];
      wr_item.is_ext        = (req_chan.rx_byte[7:1] == cfg.ext_code);
      wr_item.len_lt2       = (req_chan.rx_byte[7:1] < 7'd2);
      wr_item.is_crc_char   = (req_chan.rx_byte == cfg.crc_char);
      wr_item.is_plain_char = (req_chan.rx_byte == cfg.plain_char);
      wr_item.is_zero       = (req_chan.rx_byte == 8'd0);
   end

endmodule

### design/rpd_fifo.sv
// Short queue of classified items between the classifier and the parser.
module rpd_fifo import rpd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   output logic           wr_ready,
   input  item_class_type wr_item,
   output logic           rd_valid,
   input  logic           rd_ready,
   output item_class_type rd_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_class_type   entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = entries_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

### design/rpd_back.sv
// Packet parser: length, char, error byte, payload, CRC check, result register.
module rpd_back import rpd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           q_valid,
   output logic           q_ready,
   input  item_class_type q_item,
   rpd_rsp_if.source      rsp_chan
);

   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_rem_ff, bytes_rem_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [31:0] crc_run_ff, crc_run_in;
   logic [31:0] crc_rcv_ff, crc_rcv_in;
   logic        crc_exp_ff, crc_exp_in;
   logic [15:0] pay_rem_ff, pay_rem_in;
   logic [15:0] pay_cnt_ff, pay_cnt_in;
   logic [2:0]  pend_status_ff, pend_status_in;
   logic [7:0]  pend_remote_ff, pend_remote_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_pvalid_ff, out_pvalid_in;
   logic        out_done_ff, out_done_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic [7:0]  out_remote_ff, out_remote_in;
   logic [15:0] out_len_ff, out_len_in;

   logic        fire;
   logic        emit;
   logic        after_err;
   logic        do_fail;
   logic        do_finish;
   logic [2:0]  fail_st, fin_st;
   logic [7:0]  fail_rem, fin_rem;
   logic [15:0] left;
   logic [15:0] len16;
   logic [7:0]  b;
   logic [31:0] crc_step;

   // take an item when the result register is free or being emptied
   assign q_ready = !out_valid_ff || rsp_chan.ready;
   assign fire    = q_valid && q_ready;
   assign b       = q_item.rx_byte;
   assign crc_step = crc_byte_update(crc_run_ff, b);

   // next state and result
   always_comb begin
      phase_in       = phase_ff;
      bytes_rem_in   = bytes_rem_ff;
      len_lo_in      = len_lo_ff;
      crc_run_in     = crc_run_ff;
      crc_rcv_in     = crc_rcv_ff;
      crc_exp_in     = crc_exp_ff;
      pay_rem_in     = pay_rem_ff;
      pay_cnt_in     = pay_cnt_ff;
      pend_status_in = pend_status_ff;
      pend_remote_in = pend_remote_ff;
      emit           = 1'b0;
      out_byte_in    = 8'd0;
      out_pvalid_in  = 1'b0;
      out_done_in    = 1'b0;
      out_status_in  = ST_OK;
      out_remote_in  = 8'd0;
      out_len_in     = 16'd0;
      after_err      = 1'b0;
      do_fail        = 1'b0;
      do_finish      = 1'b0;
      fail_st        = ST_OK;
      fail_rem       = 8'd0;
      fin_st         = ST_OK;
      fin_rem        = 8'd0;
      left           = 16'd0;
      len16          = {b, len_lo_ff};

      unique case (phase_ff)
         PH_IDLE: begin
            pay_cnt_in   = 16'd0;
            crc_exp_in   = 1'b0;
            crc_rcv_in   = 32'd0;
            bytes_rem_in = 16'd0;
            if (!q_item.is_odd) begin
               do_finish = 1'b1;
               fin_st    = ST_BAD_FIRST;
            end else begin
               crc_run_in = crc_byte_update(CRC_INIT, b);
               if (q_item.is_ext) begin
                  phase_in = PH_LEN_LO;
               end else if (q_item.len_lt2) begin
                  do_finish = 1'b1;
                  fin_st    = ST_TOO_SMALL;
               end else begin
                  bytes_rem_in = {9'd0, b[7:1]} - 16'd1;
                  phase_in     = PH_CHAR;
               end
            end
         end
         PH_LEN_LO: begin
            crc_run_in = crc_step;
            len_lo_in  = b;
            phase_in   = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            crc_run_in = crc_step;
            if (len16 < 16'd4) begin
               do_finish = 1'b1;
               fin_st    = ST_TOO_SMALL;
            end else begin
               bytes_rem_in = len16 - 16'd3;
               phase_in     = PH_CHAR;
            end
         end
         PH_CHAR: begin
            crc_run_in   = crc_step;
            bytes_rem_in = bytes_rem_ff - 16'd1;
            left         = bytes_rem_in;
            if (q_item.is_crc_char) begin
               crc_exp_in = 1'b1;
            end else if (q_item.is_plain_char) begin
               crc_exp_in = 1'b0;
            end else begin
               do_fail = 1'b1;
               fail_st = ST_BAD_CHAR;
            end
            if (!do_fail && crc_exp_in) begin
               if (bytes_rem_in < 16'd4) begin
                  do_fail = 1'b1;
                  fail_st = ST_TOO_SMALL;
               end else begin
                  left = bytes_rem_in - 16'd4;
               end
            end
            if (!do_fail) begin
               if (left == 16'd0) begin
                  if (cfg.capacity != 16'd0) begin
                     do_fail = 1'b1;
                     fail_st = ST_WRONG_SIZE;
                  end else begin
                     pay_rem_in = 16'd0;
                     after_err  = 1'b1;
                  end
               end else begin
                  pay_rem_in = left;
                  phase_in   = PH_ERRB;
               end
            end
         end
         PH_ERRB: begin
            crc_run_in   = crc_step;
            bytes_rem_in = bytes_rem_ff - 16'd1;
            pay_rem_in   = pay_rem_ff - 16'd1;
            if (!q_item.is_zero) begin
               do_fail  = 1'b1;
               fail_st  = ST_REMOTE;
               fail_rem = b;
            end else begin
               after_err = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            crc_run_in    = crc_step;
            bytes_rem_in  = bytes_rem_ff - 16'd1;
            pay_rem_in    = pay_rem_ff - 16'd1;
            pay_cnt_in    = pay_cnt_ff + 16'd1;
            emit          = 1'b1;
            out_byte_in   = b;
            out_pvalid_in = 1'b1;
            if (pay_rem_in == 16'd0) begin
               if (crc_exp_ff) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in    = PH_IDLE;
                  out_done_in = 1'b1;
                  out_len_in  = pay_cnt_in;
               end
            end
         end
         PH_CRC: begin
            crc_rcv_in   = {b, crc_rcv_ff[31:8]};
            bytes_rem_in = bytes_rem_ff - 16'd1;
            if (bytes_rem_in == 16'd0) begin
               do_finish = 1'b1;
               fin_st    = ((crc_run_ff ^ CRC_INIT) == crc_rcv_in) ? ST_OK : ST_CRC_BAD;
            end
         end
         PH_FLUSH: begin
            bytes_rem_in = bytes_rem_ff - 16'd1;
            if (bytes_rem_in == 16'd0) begin
               do_finish = 1'b1;
               fin_st    = pend_status_ff;
               fin_rem   = pend_remote_ff;
            end
         end
      endcase

      // after the char or error byte: capacity check, then payload, trailer or done
      if (after_err) begin
         if (pay_rem_in > cfg.capacity) begin
            do_fail = 1'b1;
            fail_st = ST_BUF_SMALL;
         end else if (pay_rem_in != 16'd0) begin
            phase_in = PH_PAYLOAD;
         end else if (crc_exp_in) begin
            phase_in = PH_CRC;
         end else begin
            do_finish = 1'b1;
            fin_st    = ST_OK;
         end
      end

      // error: report now if nothing is left, else flush the rest
      if (do_fail) begin
         if (bytes_rem_in == 16'd0) begin
            do_finish = 1'b1;
            fin_st    = fail_st;
            fin_rem   = fail_rem;
         end else begin
            pend_status_in = fail_st;
            pend_remote_in = fail_rem;
            phase_in       = PH_FLUSH;
         end
      end

      if (do_finish) begin
         phase_in      = PH_IDLE;
         emit          = 1'b1;
         out_byte_in   = 8'd0;
         out_pvalid_in = 1'b0;
         out_done_in   = 1'b1;
         out_status_in = fin_st;
         out_remote_in = fin_rem;
         out_len_in    = pay_cnt_in;
      end

      out_valid_in = (fire && emit) ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bytes_rem_ff   <= 16'd0;
         len_lo_ff      <= 8'd0;
         crc_run_ff     <= CRC_INIT;
         crc_rcv_ff     <= 32'd0;
         crc_exp_ff     <= 1'b0;
         pay_rem_ff     <= 16'd0;
         pay_cnt_ff     <= 16'd0;
         pend_status_ff <= ST_OK;
         pend_remote_ff <= 8'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            phase_ff       <= phase_in;
            bytes_rem_ff   <= bytes_rem_in;
            len_lo_ff      <= len_lo_in;
            crc_run_ff     <= crc_run_in;
            crc_rcv_ff     <= crc_rcv_in;
            crc_exp_ff     <= crc_exp_in;
            pay_rem_ff     <= pay_rem_in;
            pay_cnt_ff     <= pay_cnt_in;
            pend_status_ff <= pend_status_in;
            pend_remote_ff <= pend_remote_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_byte_ff   <= out_byte_in;
         out_pvalid_ff <= out_pvalid_in;
         out_done_ff   <= out_done_in;
         out_status_ff <= out_status_in;
         out_remote_ff <= out_remote_in;
         out_len_ff    <= out_len_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.payload_byte   = out_byte_ff;
   assign rsp_chan.payload_valid  = out_pvalid_ff;
   assign rsp_chan.packet_done    = out_done_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.remote_error   = out_remote_ff;
   assign rsp_chan.payload_length = out_len_ff;

endmodule

### design/response_packet_deframer_crc32_core.sv
// Response packet deframer with CRC-32 check: config registers and top level.
// A byte passes through the queue and the parser's result register before its result shows on rsp_chan.
// Throughput: one byte per cycle while rsp_chan is ready, with a table CRC update
// and counter step per byte; a two-entry queue lets input and output stall apart.
// Reset: synchronous, active high; clears parser state and restores config defaults.
`include "response_packet_deframer_crc32_core_macros.svh"
module response_packet_deframer_crc32_core import rpd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rpd_req_if.sink   req_chan,
   rpd_rsp_if.source rsp_chan,
   rpd_csr_if.sink   csr_chan
);

   cfg_type        cfg_ff, cfg_in;
   logic           q_wr_valid, q_wr_ready;
   item_class_type q_wr_item;
   logic           q_rd_valid, q_rd_ready;
   item_class_type q_rd_item;

   // config writes are always taken
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_CRC_CHAR:   cfg_in.crc_char   = csr_chan.data[7:0];
            CSR_PLAIN_CHAR: cfg_in.plain_char = csr_chan.data[7:0];
            CSR_EXT_CODE:   cfg_in.ext_code   = csr_chan.data[6:0];
            CSR_CAPACITY:   cfg_in.capacity   = csr_chan.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_char   <= 8'd0;
         cfg_ff.plain_char <= 8'd0;
         cfg_ff.ext_code   <= EXT_CODE_RESET;
         cfg_ff.capacity   <= CAPACITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpd_front u_front (
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_item  (q_wr_item)
   );

   rpd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_item  (q_wr_item),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_item  (q_rd_item)
   );

   rpd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_rd_valid),
      .q_ready  (q_rd_ready),
      .q_item   (q_rd_item),
      .rsp_chan (rsp_chan)
   );

   // a nonzero remote error only comes with the remote error status
   `RPD_ASSERT_IMPLIES(a_remote_status, clock, reset, rsp_chan.valid && rsp_chan.remote_error != 8'd0, rsp_chan.packet_done && rsp_chan.status == ST_REMOTE, "remote error without remote status")
   // a result that does not end a packet carries a payload byte
   `RPD_ASSERT_IMPLIES(a_mid_has_byte, clock, reset, rsp_chan.valid && !rsp_chan.packet_done, rsp_chan.payload_valid, "empty result outside packet end")
   // capacity write lands in the register
   `RPD_ASSERT_NEXT(a_cap_write, clock, reset, csr_chan.valid && csr_chan.ready && csr_chan.index == CSR_CAPACITY, cfg_ff.capacity == $past(csr_chan.data), "capacity write lost")

endmodule
